### sv/cog_pkg.sv
package cog_pkg;

	localparam logic [1:0] OP_LOAD_ENTRY = 2'd0;
	localparam logic [1:0] OP_LOAD_STAB  = 2'd1;
	localparam logic [1:0] OP_QUERY_COL  = 2'd2;
	localparam logic [1:0] OP_QUERY_TOT  = 2'd3;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_NBR    = 2'd1;
	localparam logic [1:0] KIND_TOTALS = 2'd2;

	localparam logic [1:0] CFG_LAMBDA = 2'd0;
	localparam logic [1:0] CFG_ROWS   = 2'd1;
	localparam logic [1:0] CFG_COLS   = 2'd2;
	localparam logic [1:0] CFG_GORDER = 2'd3;

	localparam int CFG_W = 31;
	localparam int DIV_STEPS = 31;
	localparam int DCNT_W = 5;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  col_index;
		logic [5:0]  row_index;
		logic [7:0]  entry_value;
		logic [30:0] stab_order;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        kept;
		logic [30:0] weight;
		logic [4:0]  degree;
		logic [4:0]  vertex_index;
		logic [5:0]  vertex_count;
		logic [8:0]  edge_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic capture;
		logic scan_go;
		logic scan_ortho;
		logic a_zero;
		logic a_one;
		logic a_col;
		logic a_inc;
		logic b_clr;
		logic b_inc;
		logic kept_wr;
		logic ec_upd;
		logic c_visit;
		logic adj_wr;
		logic stab_rd;
		logic div_go;
		logic emit_hdr;
		logic emit_nbr;
		logic emit_tot;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic a_last;
		logic b_last;
		logic b_next_lt_a;
		logic pair_kept;
		logic b_other_kept;
		logic col_ok;
		logic div_done;
		logic adj_b;
		logic nbr_last;
		logic deg_zero;
		logic is_tot;
	} stat_t;

endpackage

### sv/cog_ram.sv
module cog_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/cog_dp.sv
module cog_dp #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cog_pkg::item_t          item,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [cog_pkg::CFG_W-1:0] cfg_data,
	input  cog_pkg::cmd_t           cmd,
	output cog_pkg::stat_t          stat,
	output cog_pkg::result_t        result,
	output logic                    result_valid
);

	localparam int CIW   = $clog2(MAX_COLS);
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int CCW   = $clog2(MAX_COLS + 1);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(MAX_COLS * (MAX_COLS - 1) / 2 + 1);
	localparam int DCNT_W_L = cog_pkg::DCNT_W;

	// configuration
	logic [7:0]  lambda_q;
	logic [6:0]  rows_q;
	logic [5:0]  cols_q;
	logic [30:0] gorder_q;
	logic [RCW-1:0] nr;
	logic [CCW-1:0] nc;

	// captured query
	logic [1:0] op_q;
	logic [4:0] col_q;
	logic [CIW-1:0] col_idx;
	logic col_in;

	// loop indices and flags
	logic [CIW-1:0] a_q, b_q;
	logic [RCW-1:0] r_q;
	logic sbusy_q, pend_s1, hit_q, ortho_q;
	logic issue, scan_done, hnow;
	logic [MAX_COLS-1:0] kept_q, adj_q;
	logic a_lt_nc, a_keep;
	logic [CCW-1:0] vc_q, deg_q, self_q, p_q, k_q;
	logic [EW-1:0]  ec_q;

	// memories
	logic [AW-1:0] wr_addr, rd_a, rd_b;
	logic load_en, stab_en;
	logic [7:0]  ent_a, ent_b;
	logic [30:0] stab_rdata, divisor;

	// divider
	logic [30:0] rem_q, quo_q, dvs_q;
	logic [DCNT_W_L-1:0] dcnt_q;
	logic [31:0] dtry, dsub;
	logic ge;

	cog_pkg::result_t res_q, res_d;
	logic vld_q;

	assign nr = (32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q);
	assign nc = (32'(cols_q) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_q);

	assign col_idx = CIW'(col_q);
	assign col_in  = 32'(col_q) < MAX_COLS;

	assign wr_addr = AW'(item.col_index) * AW'(MAX_ROWS) + AW'(item.row_index);
	assign rd_a    = AW'(a_q) * AW'(MAX_ROWS) + AW'(r_q);
	assign rd_b    = AW'(b_q) * AW'(MAX_ROWS) + AW'(r_q);
	assign load_en = cmd.capture && (item.opcode == cog_pkg::OP_LOAD_ENTRY)
		&& (32'(item.col_index) < MAX_COLS) && (32'(item.row_index) < MAX_ROWS);
	assign stab_en = cmd.capture && (item.opcode == cog_pkg::OP_LOAD_STAB)
		&& (32'(item.col_index) < MAX_COLS);

	// two copies of the entry store so both columns of a pair read at once
	cog_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ent_a (
		.clk, .we(load_en), .waddr(wr_addr), .wdata(item.entry_value),
		.re(issue), .raddr(rd_a), .rdata(ent_a)
	);
	cog_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ent_b (
		.clk, .we(load_en), .waddr(wr_addr), .wdata(item.entry_value),
		.re(issue), .raddr(rd_b), .rdata(ent_b)
	);
	cog_ram #(.WIDTH(31), .DEPTH(MAX_COLS)) u_stab (
		.clk, .we(stab_en), .waddr(CIW'(item.col_index)), .wdata(item.stab_order),
		.re(cmd.stab_rd), .raddr(col_idx), .rdata(stab_rdata)
	);

	// row scan: kept mode flags an entry above lambda, ortho mode a nonzero product
	assign issue     = sbusy_q && (r_q != nr);
	assign scan_done = sbusy_q && !issue && !pend_s1;
	assign hnow      = ortho_q ? ((ent_a != 8'd0) && (ent_b != 8'd0)) : (ent_a > lambda_q);
	assign a_lt_nc   = 32'(a_q) < 32'(nc);
	assign a_keep    = a_lt_nc && !hit_q;

	assign divisor = col_in ? stab_rdata : 31'd0;
	assign dtry    = {rem_q, quo_q[30]};
	assign dsub    = dtry - {1'b0, dvs_q};
	assign ge      = dtry >= {1'b0, dvs_q};

	always_comb begin
		stat = '0;
		stat.scan_done    = scan_done;
		stat.a_last       = a_q == CIW'(MAX_COLS - 1);
		stat.b_last       = b_q == CIW'(MAX_COLS - 1);
		stat.b_next_lt_a  = (32'(b_q) + 1) < 32'(a_q);
		stat.pair_kept    = kept_q[a_q] && kept_q[b_q];
		stat.b_other_kept = kept_q[b_q] && (b_q != a_q);
		stat.col_ok       = (32'(col_q) < 32'(nc)) && kept_q[col_idx];
		stat.div_done     = dcnt_q == '0;
		stat.adj_b        = adj_q[b_q];
		stat.nbr_last     = (k_q + CCW'(1)) == deg_q;
		stat.deg_zero     = deg_q == '0;
		stat.is_tot       = op_q == cog_pkg::OP_QUERY_TOT;
	end

	// next result word
	always_comb begin
		res_d = res_q;
		if (cmd.emit_hdr) begin
			res_d              = '0;
			res_d.kind         = cog_pkg::KIND_HEADER;
			res_d.kept         = stat.col_ok;
			res_d.weight       = quo_q;
			res_d.degree       = 5'(deg_q);
			res_d.vertex_index = 5'(self_q);
			res_d.last         = !stat.col_ok || (deg_q == '0);
		end else if (cmd.emit_nbr) begin
			res_d              = '0;
			res_d.kind         = cog_pkg::KIND_NBR;
			res_d.kept         = 1'b1;
			res_d.vertex_index = 5'(p_q);
			res_d.last         = stat.nbr_last;
		end else if (cmd.emit_tot) begin
			res_d              = '0;
			res_d.kind         = cog_pkg::KIND_TOTALS;
			res_d.vertex_count = 6'(vc_q);
			res_d.edge_count   = 9'(ec_q);
			res_d.last         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= 8'd1;
			rows_q   <= 7'd64;
			cols_q   <= 6'd32;
			gorder_q <= 31'd1;
			sbusy_q  <= 1'b0;
			pend_s1  <= 1'b0;
			hit_q    <= 1'b0;
			ortho_q  <= 1'b0;
			r_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			kept_q   <= '0;
			adj_q    <= '0;
			vc_q     <= '0;
			ec_q     <= '0;
			deg_q    <= '0;
			self_q   <= '0;
			p_q      <= '0;
			k_q      <= '0;
			dcnt_q   <= '0;
			vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cog_pkg::CFG_LAMBDA: lambda_q <= cfg_data[7:0];
					cog_pkg::CFG_ROWS:   rows_q   <= cfg_data[6:0];
					cog_pkg::CFG_COLS:   cols_q   <= cfg_data[5:0];
					cog_pkg::CFG_GORDER: gorder_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.capture) begin
				adj_q  <= '0;
				vc_q   <= '0;
				ec_q   <= '0;
				deg_q  <= '0;
				self_q <= '0;
				p_q    <= '0;
				k_q    <= '0;
			end

			if (cmd.scan_go) begin
				sbusy_q <= 1'b1;
				pend_s1 <= 1'b0;
				hit_q   <= 1'b0;
				ortho_q <= cmd.scan_ortho;
				r_q     <= '0;
			end else if (sbusy_q) begin
				r_q     <= r_q + RCW'(issue);
				pend_s1 <= issue;
				if (pend_s1 && hnow) begin
					hit_q <= 1'b1;
				end
				if (scan_done) begin
					sbusy_q <= 1'b0;
				end
			end

			if (cmd.a_zero) begin
				a_q <= '0;
			end else if (cmd.a_one) begin
				a_q <= CIW'(1);
			end else if (cmd.a_col) begin
				a_q <= col_idx;
			end else if (cmd.a_inc) begin
				a_q <= a_q + CIW'(1);
			end

			if (cmd.b_clr) begin
				b_q <= '0;
			end else if (cmd.b_inc) begin
				b_q <= b_q + CIW'(1);
			end

			if (cmd.kept_wr) begin
				kept_q[a_q] <= a_keep;
				vc_q        <= vc_q + CCW'(a_keep);
			end
			if (cmd.ec_upd) begin
				ec_q <= ec_q + EW'(!hit_q);
			end
			if (cmd.adj_wr) begin
				adj_q[b_q] <= !hit_q;
				deg_q      <= deg_q + CCW'(!hit_q);
			end
			if (cmd.c_visit) begin
				self_q <= self_q + CCW'(kept_q[b_q] && (b_q < a_q));
			end
			if (cmd.emit_nbr) begin
				k_q <= k_q + CCW'(adj_q[b_q]);
				p_q <= p_q + CCW'(kept_q[b_q]);
			end

			if (cmd.div_go) begin
				dcnt_q <= (divisor == 31'd0) ? '0 : DCNT_W_L'(cog_pkg::DIV_STEPS);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DCNT_W_L'(1);
			end

			vld_q <= cmd.emit_hdr || cmd.emit_tot || (cmd.emit_nbr && adj_q[b_q]);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= item.opcode;
			col_q <= item.col_index;
		end

		if (cmd.div_go) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= (divisor == 31'd0) ? 31'd0 : gorder_q;
		end else if (dcnt_q != '0) begin
			rem_q <= ge ? dsub[30:0] : dtry[30:0];
			quo_q <= {quo_q[29:0], ge};
		end

		res_q <= res_d;
	end

	assign result       = res_q;
	assign result_valid = vld_q;

	a_vc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(vc_q) <= MAX_COLS)
		else $error("vertex count beyond column count");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= deg_q)
		else $error("more neighbours sent than counted");
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> !sbusy_q && !pend_s1)
		else $error("row scan did not stop");

endmodule

### sv/cog_ctrl.sv
module cog_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     opcode,
	input  cog_pkg::stat_t stat,
	output cog_pkg::cmd_t  cmd,
	output logic           busy
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_KGO   = 4'd1;
	localparam logic [3:0] S_KWAIT = 4'd2;
	localparam logic [3:0] S_KEND  = 4'd3;
	localparam logic [3:0] S_TSEL  = 4'd4;
	localparam logic [3:0] S_TWAIT = 4'd5;
	localparam logic [3:0] S_TOT   = 4'd6;
	localparam logic [3:0] S_CSEL  = 4'd7;
	localparam logic [3:0] S_CWAIT = 4'd8;
	localparam logic [3:0] S_SRD   = 4'd9;
	localparam logic [3:0] S_DLD   = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_HDR   = 4'd12;
	localparam logic [3:0] S_NBR   = 4'd13;

	logic [3:0] st_q, st_d;

	always_comb begin
		cmd  = '0;
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (opcode == cog_pkg::OP_QUERY_COL || opcode == cog_pkg::OP_QUERY_TOT) begin
						cmd.a_zero = 1'b1;
						st_d = S_KGO;
					end
				end
			end
			S_KGO: begin
				cmd.scan_go = 1'b1;
				st_d = S_KWAIT;
			end
			S_KWAIT: begin
				if (stat.scan_done) begin
					cmd.kept_wr = 1'b1;
					if (stat.a_last) begin
						st_d = S_KEND;
					end else begin
						cmd.a_inc = 1'b1;
						st_d = S_KGO;
					end
				end
			end
			S_KEND: begin
				cmd.b_clr = 1'b1;
				if (stat.is_tot) begin
					cmd.a_one = 1'b1;
					st_d = S_TSEL;
				end else if (stat.col_ok) begin
					cmd.a_col = 1'b1;
					st_d = S_CSEL;
				end else begin
					st_d = S_SRD;
				end
			end
			S_TSEL, S_TWAIT: begin
				if (st_q == S_TSEL && stat.pair_kept) begin
					cmd.scan_go    = 1'b1;
					cmd.scan_ortho = 1'b1;
					st_d = S_TWAIT;
				end else if (st_q == S_TSEL || stat.scan_done) begin
					cmd.ec_upd = (st_q == S_TWAIT);
					if (stat.b_next_lt_a) begin
						cmd.b_inc = 1'b1;
						st_d = S_TSEL;
					end else if (stat.a_last) begin
						st_d = S_TOT;
					end else begin
						cmd.a_inc = 1'b1;
						cmd.b_clr = 1'b1;
						st_d = S_TSEL;
					end
				end
			end
			S_TOT: begin
				cmd.emit_tot = 1'b1;
				st_d = S_IDLE;
			end
			S_CSEL: begin
				cmd.c_visit = 1'b1;
				if (stat.b_other_kept) begin
					cmd.scan_go    = 1'b1;
					cmd.scan_ortho = 1'b1;
					st_d = S_CWAIT;
				end else if (stat.b_last) begin
					st_d = S_SRD;
				end else begin
					cmd.b_inc = 1'b1;
				end
			end
			S_CWAIT: begin
				if (stat.scan_done) begin
					cmd.adj_wr = 1'b1;
					if (stat.b_last) begin
						st_d = S_SRD;
					end else begin
						cmd.b_inc = 1'b1;
						st_d = S_CSEL;
					end
				end
			end
			S_SRD: begin
				cmd.stab_rd = 1'b1;
				st_d = S_DLD;
			end
			S_DLD: begin
				cmd.div_go = 1'b1;
				st_d = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					st_d = S_HDR;
				end
			end
			S_HDR: begin
				cmd.emit_hdr = 1'b1;
				cmd.b_clr    = 1'b1;
				st_d = (stat.col_ok && !stat.deg_zero) ? S_NBR : S_IDLE;
			end
			S_NBR: begin
				cmd.emit_nbr = 1'b1;
				if ((stat.adj_b && stat.nbr_last) || stat.b_last) begin
					st_d = S_IDLE;
				end else begin
					cmd.b_inc = 1'b1;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	assign busy = st_q != S_IDLE;

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_hdr, cmd.emit_nbr, cmd.emit_tot}))
		else $error("two result sources at once");
	a_scan_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_go |=> st_q == S_KWAIT || st_q == S_TWAIT || st_q == S_CWAIT)
		else $error("scan started outside a wait");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> st_q == S_DIV)
		else $error("divider started without wait");

endmodule

### sv/column_orthogonality_graph.sv
// channel   | ports                            | handshake
// ----------+----------------------------------+---------------------------------
// item in   | start, busy, item                | taken when start high, busy low
// result    | result_valid, result             | one cycle per result, no stall
// config    | cfg_we, cfg_index, cfg_data      | write on cfg_we, no wait
//
// Loads leave busy low. A query first scans every column over the rows in
// use for the lambda filter, through the single read port of each entry
// store copy. A column query then checks each other kept column, runs a
// 31-step restoring divider for the weight, and walks the columns once to
// send the neighbour items; a totals query checks every kept pair in the
// same way.
// Reset gives the register defaults; the stores hold garbage until loaded.
// The receiver cannot stall: each result is shown for one cycle only.
module column_orthogonality_graph #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  cog_pkg::item_t            item,
	output logic                      result_valid,
	output cog_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [cog_pkg::CFG_W-1:0] cfg_data
);

	cog_pkg::cmd_t  cmd;
	cog_pkg::stat_t stat;

	// sequencer: loop order over columns, pairs and the output walk
	cog_ctrl u_ctrl (
		.clk, .arst_n,
		.start,
		.opcode(item.opcode),
		.stat,
		.cmd,
		.busy
	);

	// stores, row scan, counters, divider and result register
	cog_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
		.clk, .arst_n,
		.item,
		.cfg_we, .cfg_index, .cfg_data,
		.cmd,
		.stat,
		.result,
		.result_valid
	);

	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a query in flight");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("query not finished after final item");
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("query ended before final item");
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.opcode == cog_pkg::OP_LOAD_ENTRY ||
			item.opcode == cog_pkg::OP_LOAD_STAB) |=> !busy)
		else $error("load kept the block busy");

endmodule

### dv/tb_column_orthogonality_graph.sv
module tb_column_orthogonality_graph;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NROWS = 64;
	localparam int NCOLS = 32;
	localparam int FILL_ROWS = 4;
	localparam int CYCLE_LIMIT = 3000000;

	// Scoreboard: keeps its own copy of the matrix, stabiliser orders and
	// registers, works out every result a query should give, and checks the
	// results in order as they leave the block.
	class graph_scoreboard;
		logic [7:0]  entry_mem [NROWS*NCOLS];
		logic [30:0] stab_mem [NCOLS];
		logic [7:0]  lambda;
		logic [6:0]  rows;
		logic [5:0]  cols;
		logic [30:0] gorder;
		cog_pkg::result_t pending [$];
		int          errors;
		int          items;
		int          results;
		int          queries;

		function new();
			lambda = 8'd1;
			rows = 7'd64;
			cols = 6'd32;
			gorder = 31'd1;
			foreach (entry_mem[i]) entry_mem[i] = '0;
			foreach (stab_mem[i]) stab_mem[i] = '0;
			errors = 0;
			items = 0;
			results = 0;
			queries = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [cog_pkg::CFG_W-1:0] d);
			case (idx)
				cog_pkg::CFG_LAMBDA: lambda = d[7:0];
				cog_pkg::CFG_ROWS:   rows = d[6:0];
				cog_pkg::CFG_COLS:   cols = d[5:0];
				cog_pkg::CFG_GORDER: gorder = d[30:0];
				default: ;
			endcase
		endfunction

		function int used_rows();
			return (rows > NROWS) ? NROWS : int'(rows);
		endfunction

		function int used_cols();
			return (cols > NCOLS) ? NCOLS : int'(cols);
		endfunction

		// lambda filter over the rows in use
		function bit col_kept(int c);
			for (int r = 0; r < used_rows(); r++)
				if (entry_mem[c*NROWS + r] > lambda) return 0;
			return 1;
		endfunction

		function bit orthogonal(int a, int b);
			longint unsigned acc;
			acc = 0;
			for (int r = 0; r < used_rows(); r++)
				acc += entry_mem[a*NROWS + r] * entry_mem[b*NROWS + r];
			return acc == 0;
		endfunction

		function logic [30:0] col_weight(int c);
			if (stab_mem[c] == 0) return '0;
			return gorder / stab_mem[c];
		endfunction

		function void note(cog_pkg::item_t it);
			bit      keep [NCOLS];
			cog_pkg::result_t r;
			int      nc, self_idx, deg, p, k, vc, ec;
			items++;
			nc = used_cols();
			case (it.opcode)
				cog_pkg::OP_LOAD_ENTRY:
					entry_mem[it.col_index*NROWS + it.row_index] = it.entry_value;
				cog_pkg::OP_LOAD_STAB:  stab_mem[it.col_index] = it.stab_order;
				default: begin
					queries++;
					for (int i = 0; i < NCOLS; i++) keep[i] = (i < nc) && col_kept(i);
					r = '0;
					if (it.opcode == cog_pkg::OP_QUERY_TOT) begin
						vc = 0;
						ec = 0;
						for (int i = 0; i < nc; i++) begin
							if (!keep[i]) continue;
							vc++;
							for (int j = 0; j < i; j++)
								if (keep[j] && orthogonal(i, j)) ec++;
						end
						r.kind = cog_pkg::KIND_TOTALS;
						r.vertex_count = vc[5:0];
						r.edge_count = ec[8:0];
						r.last = 1'b1;
						pending.push_back(r);
					end else if (it.col_index >= nc || !keep[it.col_index]) begin
						// column out of use or filtered out: lone header
						r.kind = cog_pkg::KIND_HEADER;
						r.weight = col_weight(it.col_index);
						r.last = 1'b1;
						pending.push_back(r);
					end else begin
						self_idx = 0;
						deg = 0;
						for (int j = 0; j < it.col_index; j++)
							if (keep[j]) self_idx++;
						for (int j = 0; j < nc; j++)
							if (j != it.col_index && keep[j] && orthogonal(it.col_index, j))
								deg++;
						r.kind = cog_pkg::KIND_HEADER;
						r.kept = 1'b1;
						r.weight = col_weight(it.col_index);
						r.degree = deg[4:0];
						r.vertex_index = self_idx[4:0];
						r.last = (deg == 0);
						pending.push_back(r);
						p = 0;
						k = 1;
						for (int j = 0; j < nc; j++) begin
							if (!keep[j]) continue;
							if (j != it.col_index && orthogonal(it.col_index, j)) begin
								r = '0;
								r.kind = cog_pkg::KIND_NBR;
								r.kept = 1'b1;
								r.vertex_index = p[4:0];
								r.last = (k == deg);
								pending.push_back(r);
								k++;
							end
							p++;
						end
					end
				end
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check(cog_pkg::result_t got);
			cog_pkg::result_t want;
			results++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.kept !== want.kept)
				report($sformatf("kept %0b, want %0b", got.kept, want.kept));
			if (got.weight !== want.weight)
				report($sformatf("weight %0d, want %0d", got.weight, want.weight));
			if (got.degree !== want.degree)
				report($sformatf("degree %0d, want %0d", got.degree, want.degree));
			if (got.vertex_index !== want.vertex_index)
				report($sformatf("vertex_index %0d, want %0d", got.vertex_index,
					want.vertex_index));
			if (got.vertex_count !== want.vertex_count)
				report($sformatf("vertex_count %0d, want %0d", got.vertex_count,
					want.vertex_count));
			if (got.edge_count !== want.edge_count)
				report($sformatf("edge_count %0d, want %0d", got.edge_count,
					want.edge_count));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b", got.last, want.last));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	cog_pkg::item_t   item;
	logic             result_valid;
	cog_pkg::result_t result;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [cog_pkg::CFG_W-1:0] cfg_data;

	graph_scoreboard sb = new();
	int unsigned     cycles;
	int              n_sets;

	column_orthogonality_graph #(
		.MAX_ROWS(NROWS),
		.MAX_COLS(NCOLS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// results are read at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check(result);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				sb.pending.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one item from the falling edge and hold it until an edge sees
	// busy low. start is left high; the caller lowers it for a gap.
	task send(cog_pkg::item_t it);
		@(negedge clk);
		start = 1'b1;
		item = it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note(it);
	endtask

	task pause(int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			item = '0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Wait for every due result, then for the block to settle: a load makes
	// no result, so a margin of cycles follows before anything is changed.
	task drain();
		pause(1);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [cog_pkg::CFG_W-1:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task setup(logic [7:0] lam, logic [6:0] nr, logic [5:0] nc, logic [30:0] go);
		drain();
		n_sets++;
		write_reg(cog_pkg::CFG_LAMBDA, cog_pkg::CFG_W'(lam));
		write_reg(cog_pkg::CFG_ROWS, cog_pkg::CFG_W'(nr));
		write_reg(cog_pkg::CFG_COLS, cog_pkg::CFG_W'(nc));
		write_reg(cog_pkg::CFG_GORDER, cog_pkg::CFG_W'(go));
	endtask

	function cog_pkg::item_t load_entry(int c, int r, logic [7:0] v);
		cog_pkg::item_t it;
		it = '0;
		it.opcode = cog_pkg::OP_LOAD_ENTRY;
		it.col_index = c[4:0];
		it.row_index = r[5:0];
		it.entry_value = v;
		it.stab_order = 31'($urandom);
		return it;
	endfunction

	function cog_pkg::item_t load_stab(int c, logic [30:0] s);
		cog_pkg::item_t it;
		it = '0;
		it.opcode = cog_pkg::OP_LOAD_STAB;
		it.col_index = c[4:0];
		it.stab_order = s;
		return it;
	endfunction

	function cog_pkg::item_t query(logic [1:0] op, int c);
		cog_pkg::item_t it;
		it = '0;
		it.opcode = op;
		it.col_index = c[4:0];
		it.row_index = 6'($urandom);
		return it;
	endfunction

	// mostly zeros so that orthogonal pairs turn up, mostly small so that
	// columns survive the filter
	function logic [7:0] pick_entry();
		int n;
		n = $urandom_range(0, 9);
		if (n < 6) return 8'd0;
		if (n < 9) return 8'($urandom_range(1, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function logic [30:0] pick_stab();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'd1;
			2: return 31'h7FFF_FFFF;
			3: return 31'($urandom_range(1, 100));
			default: return 31'($urandom);
		endcase
	endfunction

	function cog_pkg::item_t pick_item();
		cog_pkg::item_t it;
		int    n;
		it = '0;
		it.col_index = 5'($urandom);
		it.row_index = 6'($urandom);
		it.entry_value = 8'($urandom);
		it.stab_order = 31'($urandom);
		n = $urandom_range(0, 9);
		if (n < 6) begin
			it.opcode = cog_pkg::OP_LOAD_ENTRY;
			it.entry_value = pick_entry();
		end else if (n == 6) begin
			it.opcode = cog_pkg::OP_LOAD_STAB;
			it.stab_order = pick_stab();
		end else if (n < 9) begin
			it.opcode = cog_pkg::OP_QUERY_COL;
		end else begin
			it.opcode = cog_pkg::OP_QUERY_TOT;
		end
		return it;
	endfunction

	initial begin
		int burst;
		int gap;
		cycles = 0;
		n_sets = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = cog_pkg::CFG_LAMBDA;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every stabiliser order and the first FILL_ROWS rows of every column
		// are written before any query; only the saturated row count case uses
		// more rows than that, and so reads back rows never written.
		for (int c = 0; c < NCOLS; c++) begin
			send(load_stab(c, pick_stab()));
			for (int r = 0; r < FILL_ROWS; r++) send(load_entry(c, r, pick_entry()));
		end

		// Directed: default lambda and columns, extreme stabiliser orders, a
		// column with the largest entry in its last row in use, first and last
		// columns.
		setup(8'd1, 7'(FILL_ROWS), 6'd32, 31'h7FFF_FFFF);
		send(load_stab(0, 31'd0));
		send(load_stab(1, 31'd1));
		send(load_stab(2, 31'h7FFF_FFFF));
		send(load_entry(31, FILL_ROWS - 1, 8'd255));
		send(load_entry(3, 0, 8'd1));
		send(query(cog_pkg::OP_QUERY_COL, 0));
		send(query(cog_pkg::OP_QUERY_COL, 1));
		send(query(cog_pkg::OP_QUERY_COL, 2));
		send(query(cog_pkg::OP_QUERY_COL, 3));
		send(query(cog_pkg::OP_QUERY_COL, 31));
		send(query(cog_pkg::OP_QUERY_TOT, 0));

		// zero rows: every column kept and all pairs adjacent; column count
		// beyond the array saturates; lambda at its floor
		setup(8'd0, 7'd0, 6'd63, 31'd1);
		send(query(cog_pkg::OP_QUERY_COL, 5));
		send(query(cog_pkg::OP_QUERY_COL, 31));
		send(query(cog_pkg::OP_QUERY_TOT, 0));

		// row count beyond the array saturates; no columns in use
		setup(8'd255, 7'd127, 6'd0, 31'd12345);
		send(query(cog_pkg::OP_QUERY_COL, 0));
		send(query(cog_pkg::OP_QUERY_TOT, 0));

		// a single column in use, queries on it and above it
		setup(8'd255, 7'd1, 6'd1, 31'd1000);
		send(query(cog_pkg::OP_QUERY_COL, 0));
		send(query(cog_pkg::OP_QUERY_COL, 7));
		send(query(cog_pkg::OP_QUERY_TOT, 0));

		// Random phases: rows stay within the filled ones; a fresh register
		// set each phase.
		for (int ph = 0; ph < 5; ph++) begin
			case ($urandom_range(0, 3))
				0: setup(8'd0, 7'($urandom_range(1, FILL_ROWS)), 6'($urandom_range(1, 32)),
					31'($urandom));
				1: setup(8'd1, 7'($urandom_range(1, FILL_ROWS)), 6'($urandom_range(16, 32)),
					31'h7FFF_FFFF);
				2: setup(8'($urandom_range(2, 254)), 7'($urandom_range(1, FILL_ROWS)),
					6'($urandom_range(1, 63)), 31'($urandom_range(1, 1000)));
				default: setup(8'd255, 7'($urandom_range(0, FILL_ROWS)),
					6'($urandom_range(2, 32)), 31'($urandom));
			endcase
			for (int n = 0; n < 22; ) begin
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst && n < 22; b++, n++) send(pick_item());
				// some bursts run straight on into the next
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				pause(gap);
			end
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d items, %0d queries and %0d results over %0d register sets",
			sb.items, sb.queries, sb.results, n_sets);
		$display("%0d mismatches, %0d results left over", sb.errors, sb.pending.size());
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
